// ===== design/quadrature_position_counter_core_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef QUADRATURE_POSITION_COUNTER_CORE_MACROS_SVH
`define QUADRATURE_POSITION_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define QPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qpc_pkg.sv =====
`timescale 1ns / 1ps
package qpc_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 14;
   localparam int LIMIT_WIDTH     = 14;
   localparam int POSITION_WIDTH  = 14;
   localparam int RAW_WIDTH       = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0]     csr_index_type;
   typedef logic signed [LIMIT_WIDTH-1:0]  limit_type;

   localparam csr_index_type CSR_ROLL_MODE  = 2'd0;
   localparam csr_index_type CSR_LOW_LIMIT  = 2'd1;
   localparam csr_index_type CSR_HIGH_LIMIT = 2'd2;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   localparam limit_type RESET_LOW_LIMIT  = -14'sd128;
   localparam limit_type RESET_HIGH_LIMIT = 14'sd127;

   // Step per {previous B, previous A, current B, current A} code.
   localparam logic signed [1:0] STEP_DELTA [16] = '{
      2'sd0,  2'sd1,  -2'sd1, 2'sd0,
      -2'sd1, 2'sd0,  2'sd0,  2'sd1,
      2'sd1,  2'sd0,  2'sd0,  -2'sd1,
      2'sd0,  -2'sd1, 2'sd1,  2'sd0
   };

endpackage

// ===== design/quadrature_position_counter_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Word
// req_      in         valid / stall      func, pin_a, pin_b, load_value
// rsp_      out        valid / stall      position, raw_count
// csr_      in         valid / ready      index, data (ready is always high)
//
// One word per cycle unless stalled. The new count is formed from the request word
// and the stored count in the accepting cycle and is shown on rsp_ in the next
// cycle. The count register feeding back into its own update sets the one-cycle
// rate. Reset (synchronous) gives count 4, previous levels 0, saturate mode and
// limits -128 / 127. req_stall is high only while a result waits under rsp_stall.
module quadrature_position_counter_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic                                   req_pin_a,
   input  logic                                   req_pin_b,
   input  logic signed [qpc_pkg::LIMIT_WIDTH-1:0] req_load_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [qpc_pkg::POSITION_WIDTH-1:0] rsp_position,
   output logic signed [qpc_pkg::RAW_WIDTH-1:0]   rsp_raw_count,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [qpc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [qpc_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import qpc_pkg::*;

   // Wide enough to compare the bounds and the stepped count without wrap.
   localparam int WORK_WIDTH = ((COUNT_WIDTH > RAW_WIDTH) ? COUNT_WIDTH : RAW_WIDTH) + 2;

   logic                          roll_mode_ff;
   limit_type                     low_limit_ff;
   limit_type                     high_limit_ff;
   logic [1:0]                    prev_levels_ff, prev_levels_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [POSITION_WIDTH-1:0] rsp_position_ff, rsp_position_in;
   logic signed [RAW_WIDTH-1:0]   rsp_raw_count_ff, rsp_raw_count_in;

   logic                          req_take;
   logic [1:0]                    cur_levels;
   logic signed [1:0]             delta;
   logic signed [WORK_WIDTH-1:0]  count_ext, stepped, lo_bound, hi_bound;
   logic signed [WORK_WIDTH-1:0]  after_hi, after_lo, load_ext, new_ext, quotient;
   logic                          round_up;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign cur_levels = {req_pin_b, req_pin_a};
   assign delta      = STEP_DELTA[{prev_levels_ff, cur_levels}];

   always_comb begin
      count_ext = {{(WORK_WIDTH-COUNT_WIDTH){count_ff[COUNT_WIDTH-1]}}, count_ff};
      stepped   = count_ext + {{(WORK_WIDTH-2){delta[1]}}, delta};
      lo_bound  = {{(WORK_WIDTH-RAW_WIDTH){low_limit_ff[LIMIT_WIDTH-1]}}, low_limit_ff, 2'b00};
      hi_bound  = {{(WORK_WIDTH-RAW_WIDTH){high_limit_ff[LIMIT_WIDTH-1]}}, high_limit_ff, 2'b11};
      load_ext  = {{(WORK_WIDTH-RAW_WIDTH){req_load_value[LIMIT_WIDTH-1]}}, req_load_value, 2'b00};

      // Upper bound is tested first, the lower bound on what that leaves.
      if (stepped > hi_bound) begin
         after_hi = roll_mode_ff ? lo_bound : hi_bound;
      end else begin
         after_hi = stepped;
      end
      if (after_hi < lo_bound) begin
         after_lo = roll_mode_ff ? hi_bound : lo_bound;
      end else begin
         after_lo = after_hi;
      end

      prev_levels_in = prev_levels_ff;
      count_in       = count_ff;
      if (req_take) begin
         if (req_func == FUNC_LOAD) begin
            count_in = load_ext[COUNT_WIDTH-1:0];
         end else begin
            count_in       = after_lo[COUNT_WIDTH-1:0];
            prev_levels_in = cur_levels;
         end
      end

      // Divide by four, truncating toward zero.
      new_ext  = {{(WORK_WIDTH-COUNT_WIDTH){count_in[COUNT_WIDTH-1]}}, count_in};
      round_up = new_ext[WORK_WIDTH-1] & (new_ext[1:0] != 2'b00);
      quotient = (new_ext >>> 2) + {{(WORK_WIDTH-1){1'b0}}, round_up};

      rsp_valid_in     = req_take | (rsp_valid_ff & rsp_stall);
      rsp_position_in  = rsp_position_ff;
      rsp_raw_count_in = rsp_raw_count_ff;
      if (req_take) begin
         rsp_position_in  = quotient[POSITION_WIDTH-1:0];
         rsp_raw_count_in = new_ext[RAW_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_mode_ff   <= 1'b0;
         low_limit_ff   <= RESET_LOW_LIMIT;
         high_limit_ff  <= RESET_HIGH_LIMIT;
         prev_levels_ff <= 2'b00;
         count_ff       <= COUNT_WIDTH'(4);
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROLL_MODE:  roll_mode_ff  <= csr_data[0];
               CSR_LOW_LIMIT:  low_limit_ff  <= limit_type'(csr_data);
               CSR_HIGH_LIMIT: high_limit_ff <= limit_type'(csr_data);
               default: ;
            endcase
         end
         prev_levels_ff <= prev_levels_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_position_ff  <= rsp_position_in;
      rsp_raw_count_ff <= rsp_raw_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_raw_count = rsp_raw_count_ff;

endmodule

// ===== design/qpc_checker.sv =====
`timescale 1ns / 1ps
`include "quadrature_position_counter_core_macros.svh"
module qpc_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [qpc_pkg::POSITION_WIDTH-1:0] rsp_position,
   input logic signed [qpc_pkg::RAW_WIDTH-1:0]   rsp_raw_count
);
   import qpc_pkg::*;

   logic signed [POSITION_WIDTH-1:0] expect_position;
   logic [POSITION_WIDTH+RAW_WIDTH-1:0] rsp_word;
   logic                             rsp_held;
   logic                             req_take;
   logic                             check_position;
   logic                             position_ok;

   // Position the raw count implies when the count is no wider than raw_count.
   assign expect_position = rsp_raw_count[RAW_WIDTH-1:2] +
      {{(POSITION_WIDTH-1){1'b0}}, rsp_raw_count[RAW_WIDTH-1] & (rsp_raw_count[1:0] != 2'b00)};

   assign rsp_word       = {rsp_position, rsp_raw_count};
   assign rsp_held       = rsp_valid && rsp_stall;
   assign req_take       = req_valid && !req_stall;
   assign check_position = (COUNT_WIDTH <= RAW_WIDTH) && rsp_valid;
   assign position_ok    = (rsp_position == expect_position);

   `QPC_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_held, rsp_valid, "stalled result dropped")
   `QPC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_word), "result changed")
   `QPC_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_take, rsp_valid, "no result after accept")
   `QPC_ASSERT_NOW(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall, "stall with no result")
   `QPC_ASSERT_NOW(a_position, clock, reset, check_position, position_ok, "bad position")

endmodule

bind quadrature_position_counter_core qpc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_qpc_checker (.*);
